### rtl/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/tet_pkg.sv
package tet_pkg;

  // Table geometry
  localparam int SLOTS       = 16;
  localparam int MAX_RESULTS = 16;
  localparam int RANK_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W       = $clog2(SLOTS + 1);
  localparam int FIRE_W      = $clog2(MAX_RESULTS + 1);

  // Field widths
  localparam int MODE_W   = 2;
  localparam int ID_W     = 8;
  localparam int DELAY_W  = 32;
  localparam int TIME_W   = 48;
  localparam int STATUS_W = 3;

  typedef enum logic [MODE_W-1:0] {
    MODE_ADD    = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_TICK   = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_FIRED     = 3'd0,
    STAT_ADDED     = 3'd1,
    STAT_REMOVED   = 3'd2,
    STAT_NOT_FOUND = 3'd3,
    STAT_FULL      = 3'd4,
    STAT_CLEARED   = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_EXEC,
    ST_SCAN,
    ST_FLUSH
  } state_t;

  typedef logic [RANK_W-1:0] rank_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic lookup;
    logic exec;
    logic scan;
    logic flush;
  } ctrl_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    mode_t mode;
    logic  found;
    logic  fire_full;
  } dp_stat_t;

endpackage

### rtl/tet_ctrl.sv
module tet_ctrl
  import tet_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  dp_stat_t   stat,
  output ctrl_cmd_t  cmd
);

  state_t state_r;
  state_t state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        cmd.lookup = 1'b1;
        state_nxt  = (stat.mode == MODE_TICK) ? ST_SCAN : ST_EXEC;
      end
      ST_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_SCAN: begin
        // walk the ranks until none is left or the result budget is spent
        cmd.scan = 1'b1;
        if (!stat.found || stat.fire_full) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        cmd.flush = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

### rtl/tet_datapath.sv
module tet_datapath
  import tet_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  ctrl_cmd_t           cmd,
  output dp_stat_t            stat,
  input  logic [MODE_W-1:0]   in_mode,
  input  logic [ID_W-1:0]     in_event_id,
  input  logic [DELAY_W-1:0]  in_delay,
  input  logic [TIME_W-1:0]   in_now_time,
  output logic                out_valid,
  output logic [ID_W-1:0]     out_result_id,
  output logic [STATUS_W-1:0] out_status,
  output logic [TIME_W-1:0]   out_fire_time,
  output logic                out_last
);

  // Latched request
  mode_t                mode_r;
  logic [ID_W-1:0]      id_r;
  logic [DELAY_W-1:0]   delay_r;
  logic [TIME_W-1:0]    now_r;
  logic [TIME_W-1:0]    cur_time_r;

  // Slot table
  logic [SLOTS-1:0]     valid_r;
  logic [TIME_W-1:0]    trig_r  [SLOTS];
  logic [ID_W-1:0]      event_r [SLOTS];
  rank_t                order_r [SLOTS];

  // Lookup results
  logic [SLOTS-1:0]     hit_r;
  logic [SLOTS-1:0]     free_r;
  rank_t                hit_rank_r;
  logic [TIME_W-1:0]    trig_new_r;
  logic [SLOTS-1:0]     due_r;

  // Tick scan
  logic [CNT_W-1:0]     scan_p_r;
  logic [FIRE_W-1:0]    fire_cnt_r;
  logic                 pend_valid_r;
  logic [ID_W-1:0]      pend_id_r;

  // Result register
  logic                 out_valid_r;
  logic [ID_W-1:0]      out_id_r;
  status_t              out_status_r;
  logic [TIME_W-1:0]    out_time_r;
  logic                 out_last_r;

  logic [SLOTS-1:0]     hit_c;
  logic [SLOTS-1:0]     free_c;
  logic                 free_seen;
  rank_t                hit_rank_c;
  logic [TIME_W:0]      trig_sum;
  logic [TIME_W-1:0]    trig_new_c;
  logic [SLOTS-1:0]     due_c;
  logic [SLOTS-1:0]     sel_c;
  logic [ID_W-1:0]      sel_id;
  logic                 hit_any;
  logic                 free_any;
  logic                 scan_found;
  logic                 scan_due;
  logic                 fire_full;
  logic                 do_fire;
  logic                 do_skip;
  logic                 add_ok;
  logic [SLOTS-1:0]     add_target;

  // Per-slot match, first free slot and rank of the matching slot
  always_comb begin
    free_seen  = 1'b0;
    hit_rank_c = '0;
    for (int i = 0; i < SLOTS; i++) begin
      hit_c[i]  = valid_r[i] && (event_r[i] == id_r);
      free_c[i] = !valid_r[i] && !free_seen;
      if (!valid_r[i]) begin
        free_seen = 1'b1;
      end
      if (hit_c[i]) begin
        hit_rank_c = hit_rank_c | order_r[i];
      end
    end
  end

  // Saturating trigger time
  assign trig_sum   = {1'b0, cur_time_r} + {{(TIME_W + 1 - DELAY_W){1'b0}}, delay_r};
  assign trig_new_c = trig_sum[TIME_W] ? {TIME_W{1'b1}} : trig_sum[TIME_W-1:0];

  // Due compare and rank select for the scan
  always_comb begin
    sel_id = '0;
    for (int i = 0; i < SLOTS; i++) begin
      due_c[i] = now_r >= trig_r[i];
      sel_c[i] = valid_r[i] && (CNT_W'(order_r[i]) == scan_p_r);
      if (sel_c[i]) begin
        sel_id = sel_id | event_r[i];
      end
    end
  end

  assign hit_any    = |hit_r;
  assign free_any   = |free_r;
  assign scan_found = |sel_c;
  assign scan_due   = |(sel_c & due_r);
  assign fire_full  = fire_cnt_r == FIRE_W'(MAX_RESULTS);
  assign do_fire    = cmd.scan && scan_found && scan_due && !fire_full;
  assign do_skip    = cmd.scan && scan_found && !scan_due && !fire_full;
  assign add_ok     = cmd.exec && (mode_r == MODE_ADD) && (hit_any || free_any);
  assign add_target = hit_any ? hit_r : free_r;

  assign stat.mode      = mode_r;
  assign stat.found     = scan_found;
  assign stat.fire_full = fire_full;

  // Control state: slot valid bits, time, scan pending and result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r      <= '0;
      cur_time_r   <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.lookup && (mode_r == MODE_TICK)) begin
        cur_time_r <= now_r;
      end
      // strobe a single result, or release the fired entry held back
      if (cmd.exec) begin
        out_valid_r <= 1'b1;
      end else if (do_fire || cmd.flush) begin
        out_valid_r <= pend_valid_r;
      end else begin
        out_valid_r <= 1'b0;
      end
      if (cmd.exec) begin
        unique case (mode_r)
          MODE_ADD:    valid_r <= (hit_any || free_any) ? (valid_r | add_target) : valid_r;
          MODE_REMOVE: valid_r <= valid_r & ~hit_r;
          MODE_CLEAR:  valid_r <= '0;
          MODE_TICK:   valid_r <= valid_r;
        endcase
      end
      if (do_fire) begin
        valid_r      <= valid_r & ~sel_c;
        pend_valid_r <= 1'b1;
      end
      if (cmd.flush) begin
        pend_valid_r <= 1'b0;
      end
    end
  end

  // Request latch and lookup registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r     <= mode_t'(in_mode);
      id_r       <= in_event_id;
      delay_r    <= in_delay;
      now_r      <= in_now_time;
      scan_p_r   <= '0;
      fire_cnt_r <= '0;
    end
    if (cmd.lookup) begin
      hit_r      <= hit_c;
      free_r     <= free_c;
      hit_rank_r <= hit_rank_c;
      trig_new_r <= trig_new_c;
      due_r      <= due_c;
    end
    if (do_skip) begin
      scan_p_r <= scan_p_r + CNT_W'(1);
    end
    if (do_fire) begin
      fire_cnt_r <= fire_cnt_r + FIRE_W'(1);
      pend_id_r  <= sel_id;
    end
  end

  // Slot payload: write on add, close rank gaps on remove and fire
  always_ff @(posedge clk) begin
    for (int i = 0; i < SLOTS; i++) begin
      if (add_ok) begin
        if (add_target[i]) begin
          trig_r[i]  <= trig_new_r;
          event_r[i] <= id_r;
          order_r[i] <= '0;
        end else if (valid_r[i] && (!hit_any || (order_r[i] < hit_rank_r))) begin
          order_r[i] <= order_r[i] + RANK_W'(1);
        end
      end
      if (cmd.exec && (mode_r == MODE_REMOVE) && hit_any) begin
        if (valid_r[i] && (order_r[i] > hit_rank_r)) begin
          order_r[i] <= order_r[i] - RANK_W'(1);
        end
      end
      if (do_fire) begin
        if (valid_r[i] && (CNT_W'(order_r[i]) > scan_p_r)) begin
          order_r[i] <= order_r[i] - RANK_W'(1);
        end
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_time_r <= '0;
      out_last_r <= 1'b1;
      out_id_r   <= (mode_r == MODE_CLEAR) ? '0 : id_r;
      unique case (mode_r)
        MODE_ADD:    out_status_r <= (hit_any || free_any) ? STAT_ADDED : STAT_FULL;
        MODE_REMOVE: out_status_r <= hit_any ? STAT_REMOVED : STAT_NOT_FOUND;
        MODE_CLEAR:  out_status_r <= STAT_CLEARED;
        MODE_TICK:   out_status_r <= STAT_FIRED;
      endcase
    end
    // hold one fired entry back so the final one can carry last
    if (do_fire || cmd.flush) begin
      out_id_r     <= pend_id_r;
      out_status_r <= STAT_FIRED;
      out_time_r   <= cur_time_r;
      out_last_r   <= cmd.flush;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_result_id = out_id_r;
  assign out_status    = out_status_r;
  assign out_fire_time = out_time_r;
  assign out_last      = out_last_r;

endmodule

### rtl/timer_event_table.sv
// Channel   Ports                                              Transfer
// input     in_mode in_event_id in_delay in_now_time           start && !busy
// result    out_result_id out_status out_fire_time out_last    out_valid, one cycle
//
// Add, remove and clear give their one result after the lookup and exec states.
// A tick goes through lookup, scan and flush; the scan looks at one age rank
// per cycle, holds its rank after each fire and ends when no rank is left or
// MAX_RESULTS entries have fired. Each fired result waits for the next fire
// or the scan end.
// rst_n is synchronous, active low, and empties the table at once.
// The receiver cannot stall; busy drops in the cycle the last result is shown.
module timer_event_table
  import tet_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [MODE_W-1:0]   in_mode,
  input  logic [ID_W-1:0]     in_event_id,
  input  logic [DELAY_W-1:0]  in_delay,
  input  logic [TIME_W-1:0]   in_now_time,
  output logic                out_valid,
  output logic [ID_W-1:0]     out_result_id,
  output logic [STATUS_W-1:0] out_status,
  output logic [TIME_W-1:0]   out_fire_time,
  output logic                out_last
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  tet_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  tet_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_mode       (in_mode),
    .in_event_id   (in_event_id),
    .in_delay      (in_delay),
    .in_now_time   (in_now_time),
    .out_valid     (out_valid),
    .out_result_id (out_result_id),
    .out_status    (out_status),
    .out_fire_time (out_fire_time),
    .out_last      (out_last)
  );

endmodule

### rtl/tet_checker.sv
`include "assert_macros.svh"

module tet_checker
  import tet_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_valid,
  input logic [ID_W-1:0]     out_result_id,
  input logic [STATUS_W-1:0] out_status,
  input logic [TIME_W-1:0]   out_fire_time,
  input logic                out_last
);

  // A transfer always makes the block busy in the next cycle
  `ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy, "busy not raised after transfer")

  // Only fired results may be followed by more results of the same request
  `ASSERT_IMPLIES(a_single_last, clk, rst_n, out_valid && (out_status != STAT_FIRED), out_last, "non-fire result without last")

  // Time field is zero unless an event fired
  `ASSERT_IMPLIES(a_time_zero, clk, rst_n, out_valid && (out_status != STAT_FIRED), out_fire_time == '0, "fire_time set on non-fire result")

  // A clear reports identifier zero
  `ASSERT_IMPLIES(a_clear_id, clk, rst_n, out_valid && (out_status == STAT_CLEARED), out_result_id == '0, "nonzero id on clear")

endmodule

bind timer_event_table tet_checker u_tet_checker (.*);

### verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import tet_pkg::*;

  localparam int                LIMIT_CYCLES = 200000;
  localparam int                RANDOM_CMDS  = 120;
  localparam logic [TIME_W-1:0] TIME_MAX     = {TIME_W{1'b1}};
  localparam logic [TIME_W-1:0] TIME_ZERO    = {TIME_W{1'b0}};

  typedef struct {
    mode_t               mode;
    logic [ID_W-1:0]     id;
    logic [DELAY_W-1:0]  delay;
    logic [TIME_W-1:0]   now;
    int                  gap;
    bit                  drain;
  } timer_cmd_t;

  typedef struct {
    logic [ID_W-1:0]   id;
    status_t           status;
    logic [TIME_W-1:0] fire_time;
    logic              last;
  } timer_result_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start;
  logic                busy;
  logic [MODE_W-1:0]   in_mode;
  logic [ID_W-1:0]     in_event_id;
  logic [DELAY_W-1:0]  in_delay;
  logic [TIME_W-1:0]   in_now_time;
  logic                out_valid;
  logic [ID_W-1:0]     out_result_id;
  logic [STATUS_W-1:0] out_status;
  logic [TIME_W-1:0]   out_fire_time;
  logic                out_last;

  // Commands waiting to be sent and results waiting to be seen
  timer_cmd_t    pending_cmds[$];
  timer_result_t expected_results[$];

  // Shadow copy of the timer table
  bit                tbl_valid[SLOTS];
  logic [TIME_W-1:0] tbl_trigger[SLOTS];
  logic [ID_W-1:0]   tbl_event[SLOTS];
  int                tbl_rank[SLOTS];
  logic [TIME_W-1:0] table_time;

  int fail_count;
  int cycle_count;
  int results_checked;
  int fired_checked;
  int cmds_by_mode[4];

  // Driver and stimulus bookkeeping
  timer_cmd_t        next_cmd;
  bit                presenting;
  bit                gap_armed;
  int                gap_left;
  bit                no_gaps;
  logic [TIME_W-1:0] stim_time;
  timer_result_t     want;

  timer_event_table i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_mode       (in_mode),
    .in_event_id   (in_event_id),
    .in_delay      (in_delay),
    .in_now_time   (in_now_time),
    .out_valid     (out_valid),
    .out_result_id (out_result_id),
    .out_status    (out_status),
    .out_fire_time (out_fire_time),
    .out_last      (out_last)
  );

  always #5 clk = ~clk;

  // Empty the shadow table
  function automatic void clear_table();
    for (int i = 0; i < SLOTS; i++) begin
      tbl_valid[i]   = 1'b0;
      tbl_trigger[i] = TIME_ZERO;
      tbl_event[i]   = '0;
      tbl_rank[i]    = 0;
    end
  endfunction

  function automatic int find_armed(logic [ID_W-1:0] id);
    for (int i = 0; i < SLOTS; i++)
      if (tbl_valid[i] && tbl_event[i] == id)
        return i;
    return -1;
  endfunction

  // Free one entry and close the gap in the age ranks
  function automatic void free_entry(int s);
    tbl_valid[s] = 1'b0;
    for (int i = 0; i < SLOTS; i++)
      if (tbl_valid[i] && tbl_rank[i] > tbl_rank[s])
        tbl_rank[i]--;
  endfunction

  // Apply one command to the shadow table and queue the results it causes
  task automatic apply_command(mode_t mode, logic [ID_W-1:0] id,
                               logic [DELAY_W-1:0] delay, logic [TIME_W-1:0] now);
    timer_result_t     batch[$];
    logic [TIME_W:0]   sum;
    logic [TIME_W-1:0] trig;
    int                s;
    int                i;
    cmds_by_mode[mode] = cmds_by_mode[mode] + 1;
    case (mode)
      MODE_ADD: begin
        sum  = {1'b0, table_time} + {{(TIME_W + 1 - DELAY_W){1'b0}}, delay};
        trig = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
        s = find_armed(id);
        if (s >= 0) begin
          free_entry(s);
        end else begin
          for (i = 0; i < SLOTS && s < 0; i++)
            if (!tbl_valid[i])
              s = i;
        end
        if (s < 0) begin
          batch.push_back(timer_result_t'{id, STAT_FULL, TIME_ZERO, 1'b0});
        end else begin
          for (i = 0; i < SLOTS; i++)
            if (tbl_valid[i])
              tbl_rank[i]++;
          tbl_valid[s]   = 1'b1;
          tbl_event[s]   = id;
          tbl_trigger[s] = trig;
          tbl_rank[s]    = 0;
          batch.push_back(timer_result_t'{id, STAT_ADDED, TIME_ZERO, 1'b0});
        end
      end
      MODE_REMOVE: begin
        s = find_armed(id);
        if (s >= 0) begin
          free_entry(s);
          batch.push_back(timer_result_t'{id, STAT_REMOVED, TIME_ZERO, 1'b0});
        end else begin
          batch.push_back(timer_result_t'{id, STAT_NOT_FOUND, TIME_ZERO, 1'b0});
        end
      end
      MODE_TICK: begin
        table_time = now;
        // Fire due entries, newest first, up to one burst
        while (batch.size() < MAX_RESULTS) begin
          s = -1;
          for (i = 0; i < SLOTS; i++)
            if (tbl_valid[i] && table_time >= tbl_trigger[i] &&
                (s < 0 || tbl_rank[i] < tbl_rank[s]))
              s = i;
          if (s < 0)
            break;
          batch.push_back(timer_result_t'{tbl_event[s], STAT_FIRED, table_time, 1'b0});
          free_entry(s);
        end
      end
      default: begin
        for (i = 0; i < SLOTS; i++)
          tbl_valid[i] = 1'b0;
        batch.push_back(timer_result_t'{'0, STAT_CLEARED, TIME_ZERO, 1'b0});
      end
    endcase
    if (batch.size() > 0)
      batch[batch.size() - 1].last = 1'b1;
    foreach (batch[k])
      expected_results.push_back(batch[k]);
  endtask

  // Idle gaps: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60)
      return 0;
    else if (r < 90)
      return $urandom_range(1, 4);
    return $urandom_range(10, 40);
  endfunction

  // Small pool of identifiers so re-adds, removes and a full table happen
  function automatic logic [ID_W-1:0] pick_id();
    if ($urandom_range(0, 99) < 85)
      return ID_W'($urandom_range(0, 23));
    return ID_W'($urandom_range(0, 255));
  endfunction

  task automatic push_cmd(mode_t mode, logic [ID_W-1:0] id, logic [DELAY_W-1:0] delay,
                          logic [TIME_W-1:0] now, bit drain);
    pending_cmds.push_back(timer_cmd_t'{mode, id, delay, now, pick_gap(), drain});
  endtask

  // Driver: present one command at a time and hold it until the transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      start       <= 1'b0;
      in_mode     <= MODE_ADD;
      in_event_id <= '0;
      in_delay    <= '0;
      in_now_time <= '0;
      presenting  = 1'b0;
      gap_armed   = 1'b0;
      gap_left    = 0;
      table_time  = TIME_ZERO;
      clear_table();
    end else begin
      presenting = start;
      if (start && !busy) begin
        apply_command(mode_t'(in_mode), in_event_id, in_delay, in_now_time);
        presenting = 1'b0;
      end
      if (!presenting && pending_cmds.size() > 0) begin
        if (!gap_armed) begin
          gap_left  = pending_cmds[0].gap;
          gap_armed = 1'b1;
        end
        if (gap_left > 0) begin
          gap_left--;
        end else if (!pending_cmds[0].drain ||
                     (expected_results.size() == 0 && !busy)) begin
          next_cmd    = pending_cmds.pop_front();
          in_mode     <= next_cmd.mode;
          in_event_id <= next_cmd.id;
          in_delay    <= next_cmd.delay;
          in_now_time <= next_cmd.now;
          presenting  = 1'b1;
          gap_armed   = 1'b0;
        end
      end
      start <= presenting;
    end
  end

  // Monitor: compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected result id %0h status %0d time %0h last %0b", $time,
                 out_result_id, out_status, out_fire_time, out_last);
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        if (want.status == STAT_FIRED)
          fired_checked++;
        if (out_result_id !== want.id) begin
          fail_count++;
          $display("%0t: result_id expected %0h actual %0h", $time, want.id, out_result_id);
        end
        if (out_status !== want.status) begin
          fail_count++;
          $display("%0t: status expected %0d actual %0d", $time, want.status, out_status);
        end
        if (out_fire_time !== want.fire_time) begin
          fail_count++;
          $display("%0t: fire_time expected %0h actual %0h", $time, want.fire_time,
                   out_fire_time);
        end
        if (out_last !== want.last) begin
          fail_count++;
          $display("%0t: last expected %0b actual %0b", $time, want.last, out_last);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results still awaited", cycle_count,
               expected_results.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    int                sel;
    logic [TIME_W:0]   t_sum;
    logic [TIME_W-1:0] t_next;
    logic [DELAY_W-1:0] d_next;

    // Directed: empty table, remove miss, exact trigger, re-arm, full table, saturation, clear
    no_gaps = 1'b0;
    push_cmd(MODE_TICK,   8'h00, 32'h0,         48'h0, 1'b0);
    push_cmd(MODE_REMOVE, 8'hAA, 32'h0,         48'h0, 1'b0);
    push_cmd(MODE_ADD,    8'h00, 32'hFFFF_FFFF, 48'h0, 1'b0);
    push_cmd(MODE_ADD,    8'h00, 32'h0,         48'h0, 1'b0);
    push_cmd(MODE_TICK,   8'h00, 32'h0,         48'h0, 1'b0);
    push_cmd(MODE_ADD,    8'hFF, 32'h0000_0010, 48'h0, 1'b0);
    for (int i = 1; i < SLOTS; i++)
      push_cmd(MODE_ADD, ID_W'(i), DELAY_W'(i * 3), 48'h0, 1'b0);
    push_cmd(MODE_ADD,    8'h80, 32'h0,         48'h0, 1'b1);
    push_cmd(MODE_ADD,    8'h05, 32'h0,         48'h0, 1'b0);
    push_cmd(MODE_TICK,   8'h00, 32'h0,         TIME_MAX - 1, 1'b0);
    push_cmd(MODE_ADD,    8'h55, 32'hFFFF_FFFF, 48'h0, 1'b0);
    push_cmd(MODE_ADD,    8'h66, 32'h0000_0001, 48'h0, 1'b0);
    push_cmd(MODE_TICK,   8'h00, 32'h0,         TIME_MAX - 1, 1'b0);
    push_cmd(MODE_TICK,   8'h00, 32'h0,         TIME_MAX, 1'b0);
    push_cmd(MODE_ADD,    8'h77, 32'h0,         48'h0, 1'b0);
    push_cmd(MODE_CLEAR,  8'h00, 32'h0,         48'h0, 1'b0);
    push_cmd(MODE_TICK,   8'h00, 32'h0,         48'h0, 1'b0);
    stim_time = TIME_ZERO;

    // Random: mostly adds and forward ticks, with removes, clears and time jumps
    for (int n = 0; n < RANDOM_CMDS; n++) begin
      no_gaps = (n >= 40 && n < 70);
      sel     = $urandom_range(0, 99);
      if ($urandom_range(0, 99) < 80)
        d_next = DELAY_W'($urandom_range(0, 32'h0004_0000));
      else if ($urandom_range(0, 1) == 0)
        d_next = DELAY_W'($urandom_range(0, 32'h0000_0100));
      else
        d_next = $urandom;
      if (sel < 50) begin
        push_cmd(MODE_ADD, pick_id(), d_next, TIME_W'({$urandom, $urandom}),
                 n == 75 || n == 110);
      end else if (sel < 65) begin
        push_cmd(MODE_REMOVE, pick_id(), $urandom, TIME_W'({$urandom, $urandom}), 1'b0);
      end else if (sel < 97) begin
        sel = $urandom_range(0, 99);
        if (sel < 85) begin
          t_sum  = {1'b0, stim_time} + (TIME_W + 1)'($urandom_range(0, 32'h0003_0000));
          t_next = t_sum[TIME_W] ? TIME_MAX : t_sum[TIME_W-1:0];
        end else if (sel < 93) begin
          t_next = TIME_W'({$urandom, $urandom});
        end else begin
          t_next = TIME_W'($urandom_range(0, 32'h0001_0000));
        end
        stim_time = t_next;
        push_cmd(MODE_TICK, ID_W'($urandom), $urandom, t_next, 1'b0);
      end else begin
        push_cmd(MODE_CLEAR, ID_W'($urandom), $urandom, TIME_W'({$urandom, $urandom}),
                 1'b0);
      end
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Drain: all commands sent and every expected result seen
    do
      @(negedge clk);
    while (pending_cmds.size() != 0 || start || busy || expected_results.size() != 0);
    repeat (SLOTS + 8) @(negedge clk);

    $display("Sent %0d adds, %0d removes, %0d ticks and %0d clears",
             cmds_by_mode[MODE_ADD], cmds_by_mode[MODE_REMOVE],
             cmds_by_mode[MODE_TICK], cmds_by_mode[MODE_CLEAR]);
    $display("Compared %0d results, %0d of them fired timers, %0d mismatches",
             results_checked, fired_checked, fail_count);
    if (fail_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
